[rtl/core/s2c_pkg.sv]
// ----------------------------------------------------------------------------
// s2c_pkg: shared constants for the spherical to Cartesian converter
// Arctangent table, CORDIC gain and fixed-point constants.
// ----------------------------------------------------------------------------
`default_nettype none
package s2c_pkg;
  localparam int unsigned TrigStagesDefault = 16;
  localparam int unsigned AtanEntries = 24;
  localparam logic signed [33:0] InvGain = 34'sh026DD3B6A;
  localparam logic signed [33:0] OneQ30 = 34'sh040000000;

  function automatic logic [31:0] atan_turn(input int unsigned idx);
    logic [31:0] v;
    unique case (idx)
      0: v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
      3: v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
      6: v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
      9: v = 32'h00145F2F;  10: v = 32'h000A2F98; 11: v = 32'h000517CC;
      12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
      15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
      18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
      21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

[rtl/core/s2c_cordic.sv]
// ----------------------------------------------------------------------------
// s2c_cordic: pipelined sine and cosine of a 16-bit binary angle
// Quadrant fold, one register stage per CORDIC iteration, clamp and unfold.
// ----------------------------------------------------------------------------
`default_nettype none
module s2c_cordic #(
  parameter int unsigned TrigStages = s2c_pkg::TrigStagesDefault
) (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic [15:0]        angle_i,
  output logic signed [31:0]      cos_o,
  output logic signed [31:0]      sin_o
);
  localparam int unsigned N = (TrigStages > s2c_pkg::AtanEntries) ?
                              s2c_pkg::AtanEntries : TrigStages;

  logic signed [33:0] x_q [N+1];
  logic signed [33:0] y_q [N+1];
  logic signed [33:0] z_q [N+1];
  logic [1:0]         q_q [N+1];

  logic [15:0] sum_a;
  logic [1:0]  quad;
  logic [15:0] resid;
  assign sum_a = angle_i + 16'h2000;
  assign quad  = sum_a[15:14];
  assign resid = angle_i - {quad, 14'b0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= s2c_pkg::InvGain;
      y_q[0] <= '0;
      z_q[0] <= {{2{resid[15]}}, resid, 16'b0};
      q_q[0] <= quad;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [31:0] at;
    logic signed [33:0] at_s, dx, dy;
    assign at   = s2c_pkg::atan_turn(i);
    assign at_s = signed'({2'b00, at});
    assign dx   = y_q[i] >>> i;
    assign dy   = x_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][33]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - at_s;
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + at_s;
        end
        q_q[i+1] <= q_q[i];
      end
    end
  end

  logic signed [33:0] xc, yc, nxc, nyc;
  always_comb begin
    xc = x_q[N];
    yc = y_q[N];
    if (xc > s2c_pkg::OneQ30) xc = s2c_pkg::OneQ30;
    if (xc < -s2c_pkg::OneQ30) xc = -s2c_pkg::OneQ30;
    if (yc > s2c_pkg::OneQ30) yc = s2c_pkg::OneQ30;
    if (yc < -s2c_pkg::OneQ30) yc = -s2c_pkg::OneQ30;
    nxc = -xc;
    nyc = -yc;
    unique case (q_q[N])
      2'd0: begin cos_o = xc[31:0];  sin_o = yc[31:0];  end
      2'd1: begin cos_o = nyc[31:0]; sin_o = xc[31:0];  end
      2'd2: begin cos_o = nxc[31:0]; sin_o = nyc[31:0]; end
      default: begin cos_o = yc[31:0]; sin_o = nxc[31:0]; end
    endcase
  end
endmodule
`default_nettype wire

[rtl/core/spherical_to_cartesian.sv]
// Throughput: one transfer per cycle unless stalled; stages advance together.
// A stall on the output holds every stage, so nothing is lost or repeated.
// Reset clears only the stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// spherical_to_cartesian: spherical vector to Cartesian components
// Two CORDIC pipelines produce the angle sines and cosines, then two
// registered multiplier stages form the Q16.16 products with saturation.
// ----------------------------------------------------------------------------
`default_nettype none
module spherical_to_cartesian #(
  parameter int unsigned TRIG_STAGES = s2c_pkg::TrigStagesDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    stall_o,
  input  wire logic signed [31:0] magnitude_i,
  input  wire logic [15:0]        azimuth_i,
  input  wire logic [15:0]        polar_i,
  output logic                    valid_o,
  input  wire logic               stall_i,
  output logic signed [31:0]      x_out_o,
  output logic signed [31:0]      y_out_o,
  output logic signed [31:0]      z_out_o
);
  localparam int unsigned N = (TRIG_STAGES > s2c_pkg::AtanEntries) ?
                              s2c_pkg::AtanEntries : TRIG_STAGES;
  // Valid chain: CORDIC input reg + N stages, then product stages 1, 2, 3.
  localparam int unsigned Depth = N + 4;

  // The pipeline moves whenever the output register is empty or being taken.
  logic en;
  logic [Depth-1:0] vld_q;
  assign en      = !vld_q[Depth-1] || !stall_i;
  assign stall_o = !en;
  assign valid_o = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], valid_i};
    end
  end

  // The magnitude rides alongside the CORDIC stages.
  logic signed [31:0] mag_q [N+1];
  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q[0] <= magnitude_i;
      for (int i = 0; i < N; i++) mag_q[i+1] <= mag_q[i];
    end
  end

  logic signed [31:0] ct, st, cp, sp;
  s2c_cordic #(.TrigStages(TRIG_STAGES)) u_az (
    .clk_i(clk_i), .en_i(en), .angle_i(azimuth_i), .cos_o(ct), .sin_o(st));
  s2c_cordic #(.TrigStages(TRIG_STAGES)) u_po (
    .clk_i(clk_i), .en_i(en), .angle_i(polar_i), .cos_o(cp), .sin_o(sp));

  // Stage P1: first products m * trig, full width.
  logic signed [63:0] px_q, py_q, pz_q;
  logic signed [31:0] sp1_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q  <= mag_q[N] * ct;
      py_q  <= mag_q[N] * st;
      pz_q  <= mag_q[N] * cp;
      sp1_q <= sp;
    end
  end

  // Rounding to Q16.16; m*trig/2^30 fits in 33 bits.
  logic signed [63:0] rx, ry, rz;
  assign rx = (px_q + 64'sh20000000) >>> 30;
  assign ry = (py_q + 64'sh20000000) >>> 30;
  assign rz = (pz_q + 64'sh20000000) >>> 30;

  // Stage P2: second products for x and y; z rounded value is carried.
  logic signed [65:0] qx_q, qy_q;
  logic signed [32:0] z2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      qx_q <= 66'($signed(rx[32:0]) * sp1_q);
      qy_q <= 66'($signed(ry[32:0]) * sp1_q);
      z2_q <= rz[32:0];
    end
  end

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sh07FFFFFFF) r = 32'sh7FFFFFFF;
    else if (v < -66'sh080000000) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  logic signed [65:0] sx, sy, zw;
  assign sx = (qx_q + 66'sh20000000) >>> 30;
  assign sy = (qy_q + 66'sh20000000) >>> 30;
  assign zw = 66'(z2_q);

  // Stage P3: saturated output register.
  always_ff @(posedge clk_i) begin
    if (en) begin
      x_out_o <= sat32(sx);
      y_out_o <= sat32(sy);
      z_out_o <= sat32(zw);
    end
  end

  // The x and z outputs must not change while held under stall.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> $stable(x_out_o) && $stable(z_out_o))
    else $error("output changed while stalled");
  // Stall is raised only while a result waits.
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i)
    else $error("spurious stall");
  // The valid bit of an item offered while not stalled enters the valid chain.
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stall_o |=> vld_q[0] == $past(valid_i))
    else $error("valid bit lost at entry");
endmodule
`default_nettype wire

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for the spherical to Cartesian converter
// A table of directed vectors is followed by random vectors. Every accepted
// result is compared against a bit-accurate CORDIC model held in the bench.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
  localparam int unsigned Stages = s2c_pkg::TrigStagesDefault;
  localparam int unsigned NumRandom = 1100;
  localparam int unsigned DrainCycles = 40;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec_t;

  typedef struct {
    logic signed [31:0] mag;
    logic [15:0]        azi;
    logic [15:0]        pol;
    bit                 known;
    vec_t               res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_i = 1'b0;
  logic signed [31:0] magnitude_i = '0;
  logic [15:0] azimuth_i = '0;
  logic [15:0] polar_i = '0;
  logic stall_o, valid_o;
  logic signed [31:0] x_out_o, y_out_o, z_out_o;

  vec_t cart_q[$];
  int unsigned n_fail = 0;
  int unsigned n_sent = 0;
  int unsigned n_seen = 0;
  bit long_hold = 1'b0;
  bit sender_done = 1'b0;

  spherical_to_cartesian dut (
    .clk_i, .rst_ni, .valid_i, .stall_o, .magnitude_i, .azimuth_i, .polar_i,
    .valid_o, .stall_i, .x_out_o, .y_out_o, .z_out_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Floor shift on 64-bit signed values; >>> on a signed operand already floors.
  function automatic longint shr_fl(longint v, int unsigned s);
    return v >>> s;
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v > 64'sh40000000) return 64'sh40000000;
    if (v < -64'sh40000000) return -64'sh40000000;
    return v;
  endfunction

  // Quadrant fold, rotation-mode CORDIC, clamp and unfold; returns cos and sin in Q2.30.
  task automatic bam_sincos(input logic [15:0] ang, output longint cs, output longint sn);
    logic [1:0]  quad;
    logic [15:0] resid;
    longint cx, cy, cz, dx, dy;
    quad = 2'((ang + 17'h2000) >> 14);
    resid = ang - {quad, 14'b0};
    cx = 64'sh26DD3B6A;
    cy = 0;
    cz = longint'($signed(resid)) * 65536;
    for (int unsigned i = 0; i < ((Stages > 24) ? 24 : Stages); i++) begin
      dx = shr_fl(cy, i);
      dy = shr_fl(cx, i);
      if (cz >= 0) begin
        cx -= dx; cy += dy; cz -= longint'(s2c_pkg::atan_turn(i));
      end else begin
        cx += dx; cy -= dy; cz += longint'(s2c_pkg::atan_turn(i));
      end
    end
    cx = clamp_unit(cx);
    cy = clamp_unit(cy);
    case (quad)
      2'd0: begin cs = cx;  sn = cy;  end
      2'd1: begin cs = -cy; sn = cx;  end
      2'd2: begin cs = -cx; sn = -cy; end
      default: begin cs = cy; sn = -cx; end
    endcase
  endtask

  function automatic longint mul_q30(longint v, longint t);
    return (v * t + 64'sh20000000) >>> 30;
  endfunction

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -64'sh80000000) return 32'sh80000000;
    return 32'(v);
  endfunction

  task automatic convert(input logic signed [31:0] mag, input logic [15:0] azi,
                         input logic [15:0] pol, output vec_t res);
    longint ct, st, cp, sp, m;
    m = longint'(mag);
    bam_sincos(azi, ct, st);
    bam_sincos(pol, cp, sp);
    res.x = sat32(mul_q30(mul_q30(m, ct), sp));
    res.y = sat32(mul_q30(mul_q30(m, st), sp));
    res.z = sat32(mul_q30(m, cp));
  endtask

  // Offers one transfer and holds it steady until the converter takes it.
  task automatic send(input logic signed [31:0] mag, input logic [15:0] azi,
                      input logic [15:0] pol, input bit known, input vec_t typed);
    vec_t pred;
    convert(mag, azi, pol, pred);
    if (known && pred !== typed) begin
      $display("%0t: table row disagrees with model: expected %h actual %h",
               $time, typed, pred);
      n_fail++;
    end
    valid_i <= 1'b1;
    magnitude_i <= mag;
    azimuth_i <= azi;
    polar_i <= pol;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    cart_q.push_back(pred);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic idle_gap();
    int unsigned gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Directed vectors. Only the zero-radius row carries a checked typed result;
  // the others rely on the model alone.
  row_t dirs[$];
  initial begin
    row_t r;
    logic [31:0] mags[6] = '{32'sh0, 32'sh00010000, 32'sh7FFFFFFF, 32'sh80000000,
                             32'shFFFFFFFF, 32'sh00000001};
    logic [15:0] angs[6] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                             16'h1FFF, 16'hFFFF};
    r.known = 1'b1;
    r.mag = 0; r.azi = 16'hFFFF; r.pol = 16'hFFFF; r.res = '{0, 0, 0};
    dirs.push_back(r);
    r.mag = 32'sh7FFFFFFF; r.azi = 0; r.pol = 0; r.res = '{0, 0, 32'sh7FFFFFFF};
    r.known = 1'b0;
    dirs.push_back(r);
    for (int i = 0; i < 6; i++) begin
      for (int j = 0; j < 3; j++) begin
        r.mag = mags[i]; r.azi = angs[(i + j) % 6]; r.pol = angs[(i + 2 * j + 1) % 6];
        dirs.push_back(r);
      end
    end
    r.mag = 32'sh80000000; r.azi = 16'h8000; r.pol = 16'h4000;
    dirs.push_back(r);
    r.mag = 32'sh80000000; r.azi = 16'h2000; r.pol = 16'hE000;
    dirs.push_back(r);
  end

  // Sender: directed table, then random vectors with one pause for a full drain.
  initial begin
    vec_t none;
    logic signed [31:0] mag;
    none = '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (dirs[k]) begin
      send(dirs[k].mag, dirs[k].azi, dirs[k].pol, dirs[k].known, dirs[k].res);
      idle_gap();
    end
    for (int unsigned k = 0; k < NumRandom; k++) begin
      case ($urandom_range(0, 3))
        0: mag = $urandom();
        1: mag = $signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000;
        2: mag = ($urandom_range(0, 1) != 0) ? 32'sh80000000 : 32'sh7FFFFFFF;
        default: mag = $signed(32'($urandom_range(0, 32'h3FFFF)));
      endcase
      send(mag, 16'($urandom()), 16'($urandom()), 1'b0, none);
      if (k == 300) begin
        // Let the pipeline empty completely before carrying on.
        valid_i <= 1'b0;
        while (cart_q.size() != 0) @(negedge clk_i);
      end else if (k < 400 || k > 500) begin
        idle_gap();
      end
      if (k == 600) long_hold = 1'b1;
    end
    valid_i <= 1'b0;
    sender_done = 1'b1;
  end

  // Receiver: random stall per result, and one long hold-off while the sender
  // keeps offering, so that the pipeline fills and stall_o rises.
  initial begin
    int unsigned hold;
    while (!sender_done || cart_q.size() != 0) begin
      @(negedge clk_i);
      if (long_hold) begin
        long_hold = 1'b0;
        stall_i <= 1'b1;
        for (hold = 0; hold < 80; hold++) @(negedge clk_i);
      end
      hold = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
      stall_i <= (hold != 0);
      if (hold != 0) begin
        repeat (hold) @(negedge clk_i);
        stall_i <= 1'b0;
      end
    end
  end

  // Result monitor, sampled at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) begin
      if (cart_q.size() == 0) begin
        $display("%0t: unexpected result %h %h %h", $time, x_out_o, y_out_o, z_out_o);
        n_fail++;
      end else begin
        vec_t e;
        e = cart_q.pop_front();
        if (x_out_o !== e.x) begin
          $display("%0t: x mismatch expected %h actual %h", $time, e.x, x_out_o);
          n_fail++;
        end
        if (y_out_o !== e.y) begin
          $display("%0t: y mismatch expected %h actual %h", $time, e.y, y_out_o);
          n_fail++;
        end
        if (z_out_o !== e.z) begin
          $display("%0t: z mismatch expected %h actual %h", $time, e.z, z_out_o);
          n_fail++;
        end
      end
      n_seen++;
    end
  end

  initial begin
    @(posedge sender_done);
    while (cart_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Converted %0d vectors (%0d directed), %0d results checked,",
             n_sent, dirs.size(), n_seen);
    $display("with random stalls on both sides, a full drain and a long output hold.");
    if (n_fail == 0 && cart_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire

[filelist.f]
rtl/core/s2c_pkg.sv
rtl/core/s2c_cordic.sv
rtl/core/spherical_to_cartesian.sv
bench/tb.sv
